// ===== rtl/rai_pkg.sv =====
// rai_pkg: shared types and constants of the ray / axis-aligned rectangle test
// holds the register index codes, axis codes, configuration and item structs
// no dependencies
package rai_pkg;

  localparam int Q_W       = 32;  // width of every Q-format field
  localparam int CFG_IDX_W = 3;   // width of the register index
  localparam int MAT_W     = 8;   // material tag width
  localparam int UV_FRAC   = 16;  // fraction bits of u/v
  localparam int TEX_W     = UV_FRAC + 1;

  // register index codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_AXIS = 3'd0,
    REG_PLANE_POS  = 3'd1,
    REG_LO_A       = 3'd2,
    REG_HI_A       = 3'd3,
    REG_LO_B       = 3'd4,
    REG_HI_B       = 3'd5,
    REG_MATERIAL   = 3'd6
  } reg_idx_t;

  // normal axis codes
  typedef enum logic [1:0] {
    AXIS_XY = 2'd0,
    AXIS_XZ = 2'd1,
    AXIS_YZ = 2'd2
  } axis_t;

  // rectangle configuration
  typedef struct packed {
    axis_t             axis;
    logic [Q_W-1:0]    pos;
    logic [Q_W-1:0]    lo_a;
    logic [Q_W-1:0]    hi_a;
    logic [Q_W-1:0]    lo_b;
    logic [Q_W-1:0]    hi_b;
    logic [MAT_W-1:0]  mat;
  } cfg_t;

  // ray fields that ride along the t divider
  typedef struct packed {
    logic [Q_W-1:0] o_x;
    logic [Q_W-1:0] o_y;
    logic [Q_W-1:0] o_z;
    logic [Q_W-1:0] d_x;
    logic [Q_W-1:0] d_y;
    logic [Q_W-1:0] d_z;
    logic [Q_W-1:0] t_lo;
    logic [Q_W-1:0] t_hi;
    logic           qneg;
    logic           miss;
  } ray_t;

  // result fields that ride along the u/v dividers, zero on a miss
  typedef struct packed {
    logic           hit;
    logic [Q_W-1:0] t;
    logic [Q_W-1:0] p_x;
    logic [Q_W-1:0] p_y;
    logic [Q_W-1:0] p_z;
    logic           ff;
  } res_t;

endpackage

// ===== rtl/rai_div.sv =====
// rai_div: pipelined restoring divider, one quotient bit per register stage
// unsigned {rem_in, num} / den with rem_in < den, side data rides along
// no package dependencies
module rai_div #(
  parameter int NW = 17,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] rem_in,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);

  // one compare and subtract step on {remainder, numerator/quotient}
  function automatic logic [DW+NW-1:0] div_step(input logic [DW+NW-1:0] w,
                                                input logic [DW-1:0] d);
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] r;
    trial = w[DW+NW-1:NW-1];
    diff  = trial - {1'b0, d};
    ge    = (trial >= {1'b0, d});
    r     = ge ? diff[DW-1:0] : trial[DW-1:0];
    return {r, w[NW-2:0], ge};
  endfunction

  logic [DW+NW-1:0] work  [NW];
  logic [DW-1:0]    dens  [NW];
  logic [SW-1:0]    sides [NW];
  logic [NW-1:0]    vld;
  logic [NW:0]      rdy;

  // ready chain, a stage moves when it is empty or its successor moves
  assign rdy[NW] = out_ready;
  assign in_ready = rdy[0];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW+NW-1:0] w_prev;
    logic [DW-1:0]    d_prev;
    logic [SW-1:0]    s_prev;
    logic             v_prev;

    assign rdy[k] = ~vld[k] | rdy[k+1];

    if (k == 0) begin : g_first
      assign w_prev = {rem_in, num};
      assign d_prev = den;
      assign s_prev = side_in;
      assign v_prev = in_valid;
    end else begin : g_next
      assign w_prev = work[k-1];
      assign d_prev = dens[k-1];
      assign s_prev = sides[k-1];
      assign v_prev = vld[k-1];
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= v_prev;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        work[k]  <= div_step(w_prev, d_prev);
        dens[k]  <= d_prev;
        sides[k] <= s_prev;
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quo       = work[NW-1][NW-1:0];
  assign side_out  = sides[NW-1];

endmodule

// ===== rtl/rai_hit.sv =====
// rai_hit: window check, hit point multiply, bound check and u/v setup stages
// depends on rai_pkg (ray_t, res_t, cfg_t, axis codes)
module rai_hit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rai_pkg::Q_W+FRAC_BITS:0] quo,
  input  rai_pkg::ray_t                   ray,
  input  rai_pkg::cfg_t                   cfg,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rai_pkg::Q_W-1:0]         rem_a,
  output logic [rai_pkg::TEX_W-1:0]       num_a,
  output logic [rai_pkg::Q_W-1:0]         den_a,
  output logic [rai_pkg::Q_W-1:0]         rem_b,
  output logic [rai_pkg::TEX_W-1:0]       num_b,
  output logic [rai_pkg::Q_W-1:0]         den_b,
  output rai_pkg::res_t                   res
);

  localparam int QW  = rai_pkg::Q_W;
  localparam int NW  = QW + FRAC_BITS + 1;     // quotient magnitude width
  localparam int PW  = 2 * QW + 1 - FRAC_BITS; // full-precision point width
  localparam int SHW = 2 * QW - FRAC_BITS;     // shifted product width

  logic [3:0] v;
  logic [4:0] rdy;

  assign rdy[4]   = out_ready;
  assign in_ready = rdy[0];
  for (genvar k = 0; k < 4; k++) begin : g_rdy
    assign rdy[k] = ~v[k] | rdy[k+1];
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
    end
  end

  // stage 1: signed t and window check on the full quotient
  logic [NW:0]     tq;
  logic [NW:0]     tlo_x;
  logic [NW:0]     thi_x;
  logic            win_miss;
  logic [QW-1:0]   s1_t;
  logic            s1_miss;
  rai_pkg::ray_t   s1_ray;

  always_comb begin
    tq       = ray.qneg ? ((~{1'b0, quo}) + (NW+1)'(1)) : {1'b0, quo};
    tlo_x    = {{(NW+1-QW){ray.t_lo[QW-1]}}, ray.t_lo};
    thi_x    = {{(NW+1-QW){ray.t_hi[QW-1]}}, ray.t_hi};
    win_miss = ($signed(tq) < $signed(tlo_x)) || ($signed(tq) > $signed(thi_x));
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_t    <= tq[QW-1:0];
      s1_miss <= ray.miss | win_miss;
      s1_ray  <= ray;
    end
  end

  // stage 2: t times each direction component
  logic [2*QW-1:0] s2_prod [3];
  logic [QW-1:0]   s2_o    [3];
  logic [QW-1:0]   s2_t;
  logic            s2_miss;
  logic            s2_ff;
  logic            ff_sel;

  always_comb begin
    unique case (cfg.axis)
      rai_pkg::AXIS_XY: ff_sel = s1_ray.d_z[QW-1];
      rai_pkg::AXIS_XZ: ff_sel = s1_ray.d_y[QW-1];
      rai_pkg::AXIS_YZ: ff_sel = s1_ray.d_x[QW-1];
      default:          ff_sel = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_prod[0] <= 64'($signed(s1_t) * $signed(s1_ray.d_x));
      s2_prod[1] <= 64'($signed(s1_t) * $signed(s1_ray.d_y));
      s2_prod[2] <= 64'($signed(s1_t) * $signed(s1_ray.d_z));
      s2_o[0]    <= s1_ray.o_x;
      s2_o[1]    <= s1_ray.o_y;
      s2_o[2]    <= s1_ray.o_z;
      s2_t       <= s1_t;
      s2_miss    <= s1_miss;
      s2_ff      <= ff_sel;
    end
  end

  // stage 3: origin plus floored product
  logic [PW-1:0] s3_p [3];
  logic [QW-1:0] s3_t;
  logic          s3_miss;
  logic          s3_ff;

  for (genvar k = 0; k < 3; k++) begin : g_pt
    logic [2*QW-1:0] sh;
    assign sh = $signed(s2_prod[k]) >>> FRAC_BITS;
    always_ff @(posedge clk) begin
      if (rdy[2]) begin
        s3_p[k] <= {{(PW-QW){s2_o[k][QW-1]}}, s2_o[k]}
                 + {sh[SHW-1], sh[SHW-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_t    <= s2_t;
      s3_miss <= s2_miss;
      s3_ff   <= s2_ff;
    end
  end

  // stage 4: bound checks, saturation and u/v divider operands
  function automatic logic [QW-1:0] sat(input logic [PW-1:0] p);
    logic [PW-1:0] mx;
    logic [PW-1:0] mn;
    mx = {{(PW-QW+1){1'b0}}, {(QW-1){1'b1}}};
    mn = {{(PW-QW+1){1'b1}}, {(QW-1){1'b0}}};
    if ($signed(p) > $signed(mx)) return mx[QW-1:0];
    if ($signed(p) < $signed(mn)) return mn[QW-1:0];
    return p[QW-1:0];
  endfunction

  logic [PW-1:0] pa;
  logic [PW-1:0] pb;
  logic [PW-1:0] loa_x, hia_x, lob_x, hib_x;
  logic [PW-1:0] ca;
  logic [PW-1:0] cb;
  logic          in_rect;
  rai_pkg::res_t res_c;

  always_comb begin
    unique case (cfg.axis)
      rai_pkg::AXIS_XY: begin pa = s3_p[0]; pb = s3_p[1]; end
      rai_pkg::AXIS_XZ: begin pa = s3_p[0]; pb = s3_p[2]; end
      default:          begin pa = s3_p[1]; pb = s3_p[2]; end
    endcase
    loa_x   = {{(PW-QW){cfg.lo_a[QW-1]}}, cfg.lo_a};
    hia_x   = {{(PW-QW){cfg.hi_a[QW-1]}}, cfg.hi_a};
    lob_x   = {{(PW-QW){cfg.lo_b[QW-1]}}, cfg.lo_b};
    hib_x   = {{(PW-QW){cfg.hi_b[QW-1]}}, cfg.hi_b};
    in_rect = ~s3_miss
            && ($signed(pa) >= $signed(loa_x)) && ($signed(pa) <= $signed(hia_x))
            && ($signed(pb) >= $signed(lob_x)) && ($signed(pb) <= $signed(hib_x));
    ca      = pa - loa_x;
    cb      = pb - lob_x;
    res_c.hit = in_rect;
    res_c.t   = in_rect ? s3_t : '0;
    res_c.p_x = in_rect ? sat(s3_p[0]) : '0;
    res_c.p_y = in_rect ? sat(s3_p[1]) : '0;
    res_c.p_z = in_rect ? sat(s3_p[2]) : '0;
    res_c.ff  = in_rect & s3_ff;
  end

  // (c - lo) * 2^16 split as remainder preload and low numerator bits
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      rem_a <= {1'b0, ca[QW-1:1]};
      num_a <= {ca[0], {rai_pkg::UV_FRAC{1'b0}}};
      den_a <= cfg.hi_a - cfg.lo_a;
      rem_b <= {1'b0, cb[QW-1:1]};
      num_b <= {cb[0], {rai_pkg::UV_FRAC{1'b0}}};
      den_b <= cfg.hi_b - cfg.lo_b;
      res   <= res_c;
    end
  end

  assign out_valid = v[3];

endmodule

// ===== rtl/ray_axis_rect_intersect.sv =====
// ray_axis_rect_intersect: ray test against one configured axis-aligned rectangle
// depends on rai_pkg, rai_div and rai_hit
//
// Usage: rays enter on the in_valid/in_ready channel (origin, direction and
// the accepted t window), one result item leaves on out_valid/out_ready for
// every ray. A miss gives an item with all fields zero. The rectangle is set
// through the cfg_valid/cfg_ready write channel (cfg_index selects the
// register, cfg_data carries the value); cfg_ready is always high. The user
// must make writes only while no ray is in flight, not enforced by the block.
// The pipeline holds one setup stage, the t divider with one quotient bit per
// stage (33 + FRAC_BITS stages), four stages for window check, multiply, hit
// point and bounds, and the u/v dividers with 17 stages. A new ray is taken
// every cycle unless a stalled receiver has filled the pipeline.
// Every stage holds its item while the next one is full, so a stalled
// receiver fills the pipeline and bubbles collapse; in_ready drops only once
// every stage is occupied. Reset empties the pipeline and restores the
// register reset values.
module ray_axis_rect_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rai_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rai_pkg::Q_W-1:0]           cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rai_pkg::Q_W-1:0]    origin_x,
  input  logic signed [rai_pkg::Q_W-1:0]    origin_y,
  input  logic signed [rai_pkg::Q_W-1:0]    origin_z,
  input  logic signed [rai_pkg::Q_W-1:0]    dir_x,
  input  logic signed [rai_pkg::Q_W-1:0]    dir_y,
  input  logic signed [rai_pkg::Q_W-1:0]    dir_z,
  input  logic signed [rai_pkg::Q_W-1:0]    t_lo,
  input  logic signed [rai_pkg::Q_W-1:0]    t_hi,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic signed [rai_pkg::Q_W-1:0]    hit_t,
  output logic signed [rai_pkg::Q_W-1:0]    point_x,
  output logic signed [rai_pkg::Q_W-1:0]    point_y,
  output logic signed [rai_pkg::Q_W-1:0]    point_z,
  output logic                              front_side,
  output logic [rai_pkg::TEX_W-1:0]         tex_u,
  output logic [rai_pkg::TEX_W-1:0]         tex_v,
  output logic [rai_pkg::MAT_W-1:0]         hit_material
);

  localparam int QW = rai_pkg::Q_W;
  localparam int NW = QW + FRAC_BITS + 1;
  localparam int RW = $bits(rai_pkg::ray_t);
  localparam int SW = $bits(rai_pkg::res_t);

  // configuration registers
  rai_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis <= rai_pkg::AXIS_XY;
      cfg.pos  <= '0;
      cfg.lo_a <= '0;
      cfg.hi_a <= QW'(65536);
      cfg.lo_b <= '0;
      cfg.hi_b <= QW'(65536);
      cfg.mat  <= '0;
    end else if (cfg_valid) begin
      unique case (rai_pkg::reg_idx_t'(cfg_index))
        rai_pkg::REG_PLANE_AXIS: cfg.axis <= rai_pkg::axis_t'(cfg_data[1:0]);
        rai_pkg::REG_PLANE_POS:  cfg.pos  <= cfg_data;
        rai_pkg::REG_LO_A:       cfg.lo_a <= cfg_data;
        rai_pkg::REG_HI_A:       cfg.hi_a <= cfg_data;
        rai_pkg::REG_LO_B:       cfg.lo_b <= cfg_data;
        rai_pkg::REG_HI_B:       cfg.hi_b <= cfg_data;
        rai_pkg::REG_MATERIAL:   cfg.mat  <= cfg_data[rai_pkg::MAT_W-1:0];
        default: ;
      endcase
    end
  end

  // setup stage: pick the normal axis, form |numerator|, |divisor| and sign
  logic [QW-1:0]   o_n;
  logic [QW-1:0]   d_n;
  logic            bad_axis;
  logic [QW:0]     diff;
  logic [QW:0]     diff_mag;
  logic [QW-1:0]   d_mag;
  rai_pkg::ray_t   ray_c;

  always_comb begin
    bad_axis = 1'b0;
    unique case (cfg.axis)
      rai_pkg::AXIS_XY: begin o_n = origin_z; d_n = dir_z; end
      rai_pkg::AXIS_XZ: begin o_n = origin_y; d_n = dir_y; end
      rai_pkg::AXIS_YZ: begin o_n = origin_x; d_n = dir_x; end
      default:          begin o_n = '0; d_n = '0; bad_axis = 1'b1; end
    endcase
    diff     = {cfg.pos[QW-1], cfg.pos} - {o_n[QW-1], o_n};
    diff_mag = diff[QW] ? (~diff + (QW+1)'(1)) : diff;
    d_mag    = d_n[QW-1] ? (~d_n + QW'(1)) : d_n;
    ray_c.o_x  = origin_x;
    ray_c.o_y  = origin_y;
    ray_c.o_z  = origin_z;
    ray_c.d_x  = dir_x;
    ray_c.d_y  = dir_y;
    ray_c.d_z  = dir_z;
    ray_c.t_lo = t_lo;
    ray_c.t_hi = t_hi;
    ray_c.qneg = diff[QW] ^ d_n[QW-1];
    ray_c.miss = bad_axis || (d_n == '0) || (cfg.hi_a == cfg.lo_a)
              || (cfg.hi_b == cfg.lo_b);
  end

  logic            f_valid;
  logic            f_ready;
  logic [NW-1:0]   f_num;
  logic [QW-1:0]   f_den;
  rai_pkg::ray_t   f_ray;
  logic            tdiv_ready;

  assign f_ready  = ~f_valid | tdiv_ready;
  assign in_ready = f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready) begin
      f_num <= {diff_mag, {FRAC_BITS{1'b0}}};
      f_den <= d_mag;
      f_ray <= ray_c;
    end
  end

  // t divider
  logic            tq_valid;
  logic            tq_ready;
  logic [NW-1:0]   tq;
  logic [RW-1:0]   tq_side;

  rai_div #(.NW(NW), .DW(QW), .SW(RW)) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (tdiv_ready),
    .rem_in    ('0),
    .num       (f_num),
    .den       (f_den),
    .side_in   (f_ray),
    .out_valid (tq_valid),
    .out_ready (tq_ready),
    .quo       (tq),
    .side_out  (tq_side)
  );

  // window, hit point and bounds
  logic                          h_valid;
  logic                          h_ready;
  logic [QW-1:0]                 rem_a, den_a, rem_b, den_b;
  logic [rai_pkg::TEX_W-1:0]     num_a, num_b;
  rai_pkg::res_t                 h_res;

  rai_hit #(.FRAC_BITS(FRAC_BITS)) u_hit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tq_valid),
    .in_ready  (tq_ready),
    .quo       (tq),
    .ray       (rai_pkg::ray_t'(tq_side)),
    .cfg       (cfg),
    .out_valid (h_valid),
    .out_ready (h_ready),
    .rem_a     (rem_a),
    .num_a     (num_a),
    .den_a     (den_a),
    .rem_b     (rem_b),
    .num_b     (num_b),
    .den_b     (den_b),
    .res       (h_res)
  );

  // u/v dividers run in lockstep on the same handshake
  logic                      u_in_ready, v_in_ready;
  logic                      u_valid, v_valid;
  logic [rai_pkg::TEX_W-1:0] u_q, v_q;
  logic [SW-1:0]             u_side;
  logic                      v_hit;

  assign h_ready = u_in_ready & v_in_ready;

  rai_div #(.NW(rai_pkg::TEX_W), .DW(QW), .SW(SW)) u_udiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (h_valid),
    .in_ready  (u_in_ready),
    .rem_in    (rem_a),
    .num       (num_a),
    .den       (den_a),
    .side_in   (h_res),
    .out_valid (u_valid),
    .out_ready (out_ready),
    .quo       (u_q),
    .side_out  (u_side)
  );

  rai_div #(.NW(rai_pkg::TEX_W), .DW(QW), .SW(1)) u_vdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (h_valid),
    .in_ready  (v_in_ready),
    .rem_in    (rem_b),
    .num       (num_b),
    .den       (den_b),
    .side_in   (h_res.hit),
    .out_valid (v_valid),
    .out_ready (out_ready),
    .quo       (v_q),
    .side_out  (v_hit)
  );

  // result item
  rai_pkg::res_t o_res;
  assign o_res = rai_pkg::res_t'(u_side);

  assign out_valid    = u_valid;
  assign hit          = o_res.hit;
  assign hit_t        = o_res.t;
  assign point_x      = o_res.p_x;
  assign point_y      = o_res.p_y;
  assign point_z      = o_res.p_z;
  assign front_side   = o_res.ff;
  assign tex_u        = o_res.hit ? u_q : '0;
  assign tex_v        = v_hit ? v_q : '0;
  assign hit_material = o_res.hit ? cfg.mat : '0;

  // checks
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    (u_valid == v_valid) && (!u_valid || (v_hit == o_res.hit)))
    else $error("u and v dividers out of step");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage is empty");

  a_uv_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> (tex_u <= rai_pkg::TEX_W'(65536)) && (tex_v <= rai_pkg::TEX_W'(65536)))
    else $error("u/v above one on a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> (hit_t == '0) && (point_x == '0) && (point_y == '0)
                          && (point_z == '0) && !front_side)
    else $error("miss item carries nonzero fields");

endmodule
